### sv/mld_pkg.sv
package mld_pkg;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 23;

   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_PER_PIXEL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_LIMIT     = 1'd1;

   localparam logic [15:0] APP_RESET   = 16'd2330;
   localparam logic [22:0] LIMIT_RESET = 23'd4147655;

   // CORDIC start value (inverse gain) in Q2.30.
   localparam logic signed [31:0] CORDIC_K = 32'sd652032874;

   localparam int TAB_LEN   = 24;
   localparam int TAB_IDX_W = 5;

   // atan(2^-i) at 2^32 units per turn.
   localparam logic [31:0] ATAN_TAB [0:TAB_LEN-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   localparam logic signed [64:0] HALF_Q45 = 65'sd17592186044416;
   localparam logic signed [32:0] HALF_Q15 = 33'sd16384;

   typedef struct packed {
      logic        start;
      logic [31:0] angle;
   } cordic_cmd_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] cos_val;
      logic signed [31:0] sin_val;
   } cordic_res_type;

   function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
      logic signed [15:0] r;
      if (v > 20'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Round a Q4.60 product to Q1.15, optionally negated first.
   function automatic logic signed [15:0] round_q45(input logic signed [63:0] p,
                                                    input logic neg);
      logic signed [64:0] t;
      logic signed [64:0] s;
      t = neg ? (HALF_Q45 - 65'(p)) : (65'(p) + HALF_Q45);
      s = t >>> 45;
      return sat16(s[19:0]);
   endfunction

   function automatic logic signed [15:0] round_q15(input logic signed [31:0] v);
      logic signed [32:0] t;
      logic signed [32:0] s;
      t = 33'(v) + HALF_Q15;
      s = t >>> 15;
      return sat16(20'(s));
   endfunction

endpackage

### sv/mld_cordic.sv
module mld_cordic #(
   parameter int TRIG_STEPS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mld_pkg::cordic_cmd_type cmd,
   output mld_pkg::cordic_res_type res
);
   import mld_pkg::*;

   localparam int SW = $clog2(TRIG_STEPS);

   typedef enum logic [2:0] {
      C_IDLE = 3'b001,
      C_ROT  = 3'b010,
      C_MAP  = 3'b100
   } cstate_type;

   cstate_type         state_ff, state_in;
   logic [SW-1:0]      step_ff, step_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [31:0] z_ff, z_in;
   logic [1:0]         quad_ff, quad_in;
   logic signed [31:0] cos_ff, cos_in;
   logic signed [31:0] sin_ff, sin_in;
   logic               done_ff, done_in;

   logic [31:0]        fold_sum;
   logic [31:0]        fold_rem;
   logic signed [31:0] xs, ys, at;

   // Fold the angle to within an eighth of a turn around a quadrant axis.
   assign fold_sum = cmd.angle + 32'h2000_0000;
   assign fold_rem = cmd.angle - {fold_sum[31:30], 30'd0};

   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;
   assign at = $signed(ATAN_TAB[TAB_IDX_W'(step_ff)]);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      quad_in  = quad_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      done_in  = 1'b0;
      case (state_ff)
         C_IDLE: begin
            if (cmd.start) begin
               x_in     = CORDIC_K;
               y_in     = '0;
               z_in     = $signed(fold_rem);
               quad_in  = fold_sum[31:30];
               step_in  = '0;
               state_in = C_ROT;
            end
         end
         C_ROT: begin
            if (!z_ff[31]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == SW'(TRIG_STEPS - 1)) begin
               state_in = C_MAP;
            end
         end
         C_MAP: begin
            case (quad_ff)
               2'd0: begin
                  cos_in = x_ff;
                  sin_in = y_ff;
               end
               2'd1: begin
                  cos_in = -y_ff;
                  sin_in = x_ff;
               end
               2'd2: begin
                  cos_in = -x_ff;
                  sin_in = -y_ff;
               end
               default: begin
                  cos_in = y_ff;
                  sin_in = -x_ff;
               end
            endcase
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign res.done    = done_ff;
   assign res.cos_val = cos_ff;
   assign res.sin_val = sin_ff;

endmodule

### sv/mouse_look_direction.sv
// Each request steps through S_MULX, S_MULY, S_PACC, S_PSTART, S_PWAIT, S_YWAIT, S_MULA,
// S_MULB and S_FIN; S_FIN holds while a result beat is stalled by rsp_ready low.
// req_ready is low while an item works, so a new request is taken only after the last result is loaded.
// The work is done by the CORDIC unit, run twice per item (pitch, then yaw), one rotation a
// cycle, plus one 32x32 multiplier that forms the four products in turn.
// Reset (synchronous, active high) restores register defaults, zeroes both angles and the pointer.
module mouse_look_direction #(
   parameter int ANGLE_BITS = 24,
   parameter int TRIG_STEPS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [15:0]               req_pointer_x,
   input  logic signed [15:0]               req_pointer_y,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [15:0]               rsp_dir_x,
   output logic signed [15:0]               rsp_dir_y,
   output logic signed [15:0]               rsp_dir_z,
   output logic [23:0]                      rsp_yaw_angle,
   output logic signed [23:0]               rsp_pitch_angle,
   input  logic                             csr_wr_en,
   input  logic [mld_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mld_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import mld_pkg::*;

   localparam int PW = ((ANGLE_BITS > 34) ? ANGLE_BITS : 34) + 1;
   localparam logic [PW-1:0] QUARTER = PW'(1) << (ANGLE_BITS - 2);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_MULX   = 10'b00_0000_0010,
      S_MULY   = 10'b00_0000_0100,
      S_PACC   = 10'b00_0000_1000,
      S_PSTART = 10'b00_0001_0000,
      S_PWAIT  = 10'b00_0010_0000,
      S_YWAIT  = 10'b00_0100_0000,
      S_MULA   = 10'b00_1000_0000,
      S_MULB   = 10'b01_0000_0000,
      S_FIN    = 10'b10_0000_0000
   } state_type;

   state_type                    state_ff, state_in;
   logic                         seen_ff, seen_in;
   logic signed [15:0]           last_x_ff, last_x_in;
   logic signed [15:0]           last_y_ff, last_y_in;
   logic signed [16:0]           dx_ff, dx_in;
   logic signed [16:0]           dy_ff, dy_in;
   logic [ANGLE_BITS-1:0]        yaw_ff, yaw_in;
   logic signed [ANGLE_BITS-1:0] pitch_ff, pitch_in;
   logic [15:0]                  app_ff, app_in;
   logic [22:0]                  lim_ff, lim_in;
   logic signed [63:0]           prod_ff, prod_in;
   logic signed [31:0]           cp_ff, cp_in;
   logic signed [31:0]           sp_ff, sp_in;
   logic signed [31:0]           cy_ff, cy_in;
   logic signed [31:0]           sy_ff, sy_in;
   logic signed [15:0]           dirx_ff, dirx_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]           rsp_x_ff, rsp_x_in;
   logic signed [15:0]           rsp_y_ff, rsp_y_in;
   logic signed [15:0]           rsp_z_ff, rsp_z_in;
   logic [23:0]                  rsp_yaw_ff, rsp_yaw_in;
   logic signed [23:0]           rsp_pitch_ff, rsp_pitch_in;

   logic signed [15:0]           ref_x, ref_y;
   logic signed [31:0]           mul_a, mul_b;
   logic signed [63:0]           mul_p;
   logic [31:0]                  ya, pa;
   logic [PW-1:0]                lim_wide;
   logic signed [PW-1:0]         lim_s;
   logic signed [PW-1:0]         psum;
   logic signed [PW-1:0]         psum_clamped;
   cordic_cmd_type               cmd;
   cordic_res_type               cres;

   mld_cordic #(
      .TRIG_STEPS(TRIG_STEPS)
   ) u_cordic (
      .clock(clock),
      .reset(reset),
      .cmd  (cmd),
      .res  (cres)
   );

   assign req_ready = (state_ff == S_IDLE);

   // The very first position only records itself, so its deltas are zero.
   assign ref_x = seen_ff ? last_x_ff : req_pointer_x;
   assign ref_y = seen_ff ? last_y_ff : req_pointer_y;

   assign mul_p = mul_a * mul_b;

   // Angles widened to 2^32 units per turn.
   assign ya = 32'(yaw_ff) << (32 - ANGLE_BITS);
   assign pa = 32'(pitch_ff) << (32 - ANGLE_BITS);

   assign lim_wide = (PW'(lim_ff) > QUARTER) ? QUARTER : PW'(lim_ff);
   assign lim_s    = $signed(lim_wide);
   assign psum     = PW'(pitch_ff) + PW'($signed(prod_ff[33:0]));

   always_comb begin
      if (psum > lim_s) begin
         psum_clamped = lim_s;
      end else if (psum < -lim_s) begin
         psum_clamped = -lim_s;
      end else begin
         psum_clamped = psum;
      end
   end

   always_comb begin
      state_in     = state_ff;
      seen_in      = seen_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      app_in       = app_ff;
      lim_in       = lim_ff;
      prod_in      = prod_ff;
      cp_in        = cp_ff;
      sp_in        = sp_ff;
      cy_in        = cy_ff;
      sy_in        = sy_ff;
      dirx_in      = dirx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_yaw_in   = rsp_yaw_ff;
      rsp_pitch_in = rsp_pitch_ff;
      mul_a        = '0;
      mul_b        = '0;
      cmd          = '0;

      if (csr_wr_en) begin
         case (csr_index)
            REG_ANGLE_PER_PIXEL: app_in = csr_wr_data[15:0];
            REG_PITCH_LIMIT:     lim_in = csr_wr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dx_in     = 17'(req_pointer_x) - 17'(ref_x);
               dy_in     = 17'(ref_y) - 17'(req_pointer_y);
               last_x_in = req_pointer_x;
               last_y_in = req_pointer_y;
               seen_in   = 1'b1;
               state_in  = S_MULX;
            end
         end
         S_MULX: begin
            mul_a    = 32'(dx_ff);
            mul_b    = 32'(app_ff);
            prod_in  = mul_p;
            state_in = S_MULY;
         end
         S_MULY: begin
            mul_a    = 32'(dy_ff);
            mul_b    = 32'(app_ff);
            prod_in  = mul_p;
            yaw_in   = yaw_ff + prod_ff[ANGLE_BITS-1:0];
            state_in = S_PACC;
         end
         S_PACC: begin
            pitch_in = psum_clamped[ANGLE_BITS-1:0];
            state_in = S_PSTART;
         end
         S_PSTART: begin
            cmd.start = 1'b1;
            cmd.angle = pa;
            state_in  = S_PWAIT;
         end
         S_PWAIT: begin
            if (cres.done) begin
               cp_in     = cres.cos_val;
               sp_in     = cres.sin_val;
               cmd.start = 1'b1;
               cmd.angle = ya;
               state_in  = S_YWAIT;
            end
         end
         S_YWAIT: begin
            if (cres.done) begin
               cy_in    = cres.cos_val;
               sy_in    = cres.sin_val;
               state_in = S_MULA;
            end
         end
         S_MULA: begin
            mul_a    = cp_ff;
            mul_b    = sy_ff;
            prod_in  = mul_p;
            state_in = S_MULB;
         end
         S_MULB: begin
            mul_a    = cp_ff;
            mul_b    = cy_ff;
            prod_in  = mul_p;
            dirx_in  = round_q45(prod_ff, 1'b0);
            state_in = S_FIN;
         end
         S_FIN: begin
            // The output register must be empty or emptying this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = dirx_ff;
               rsp_y_in     = round_q15(sp_ff);
               rsp_z_in     = round_q45(prod_ff, 1'b1);
               rsp_yaw_in   = ya[31:8];
               rsp_pitch_in = pa[31:8];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seen_ff      <= 1'b0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         yaw_ff       <= '0;
         pitch_ff     <= '0;
         app_ff       <= APP_RESET;
         lim_ff       <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         app_ff       <= app_in;
         lim_ff       <= lim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      prod_ff      <= prod_in;
      cp_ff        <= cp_in;
      sp_ff        <= sp_in;
      cy_ff        <= cy_in;
      sy_ff        <= sy_in;
      dirx_ff      <= dirx_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_z_ff     <= rsp_z_in;
      rsp_yaw_ff   <= rsp_yaw_in;
      rsp_pitch_ff <= rsp_pitch_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dir_x       = rsp_x_ff;
   assign rsp_dir_y       = rsp_y_ff;
   assign rsp_dir_z       = rsp_z_ff;
   assign rsp_yaw_angle   = rsp_yaw_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;

endmodule

### sv/mld_checker.sv
module mld_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [15:0]               rsp_dir_x,
   input logic signed [15:0]               rsp_dir_y,
   input logic signed [15:0]               rsp_dir_z,
   input logic [23:0]                      rsp_yaw_angle,
   input logic signed [23:0]               rsp_pitch_angle
);

   // A taken request keeps the block busy for at least the next cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after a request beat");

   // A new result is loaded only as the sequencer returns to idle.
   a_result_frees_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result appeared while an item is still in work");

   // Pitch never passes a quarter turn.
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 24'sd4194304 && rsp_pitch_angle >= -24'sd4194304))
      else $error("pitch beyond a quarter turn");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_dir_x) && $stable(rsp_dir_y)
         && $stable(rsp_dir_z) && $stable(rsp_yaw_angle) && $stable(rsp_pitch_angle)))
      else $error("stalled result beat changed");

endmodule

bind mouse_look_direction mld_checker u_mld_checker (.*);
